>>> rtl/core/slcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants shared by the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam logic [7:0] SYNC_RESET = 8'hFF;
    localparam logic [7:0] IDLE_BYTE  = 8'h00;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] frame_length;
        logic [7:0] received_count;
        logic [7:0] running_sum;
    } frame_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
    } result_t;

endpackage

>>> rtl/core/sync_length_checksum_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Hunts for a sync byte, then takes length, payload and checksum; emits each
// payload byte and a good/bad verdict at the end of every frame.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | rx_byte
//  out     | out_valid / out_ready| kind, payload_byte, payload_index
//  cfg     | cfg_valid / cfg_ready| cfg_data (sync value)
//
//  one byte per cycle unless a held result stalls it: a byte waits in the input
//  register, and its result is loaded into the result register as it leaves.
//  zero bytes are idle and give no result.
//  a held result stalls the input register only when the next byte has one.
//  reset: hunting, sync value 0xff, no result pending.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer
    import slcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic         stage_valid_reg;
    logic         stage_valid_next;
    logic [7:0]   stage_byte_reg;
    logic [7:0]   sync_value_reg;
    frame_state_t state_reg;
    frame_state_t state_next;
    logic         has_result;
    result_t      result;
    logic         out_free;
    logic         stage_fire;

    slcd_parse u_parse (
        .rx_byte    (stage_byte_reg),
        .sync_value (sync_value_reg),
        .cur        (state_reg),
        .nxt        (state_next),
        .has_result (has_result),
        .result     (result)
    );

    // the byte leaves the input register unless its result has nowhere to go
    assign stage_fire       = stage_valid_reg && (!has_result || out_free);
    assign in_ready         = !stage_valid_reg || stage_fire;
    assign stage_valid_next = in_valid ? 1'b1 : (stage_fire ? 1'b0 : stage_valid_reg);
    assign cfg_ready        = 1'b1;

    slcd_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (stage_fire && has_result),
        .result        (result),
        .free          (out_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .payload_index (payload_index)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            sync_value_reg  <= SYNC_RESET;
            state_reg       <= '{phase: PH_HUNT, frame_length: 8'd0,
                                 received_count: 8'd0, running_sum: 8'd0};
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= stage_valid_next;
            end
            if (cfg_valid)
            begin
                sync_value_reg <= cfg_data;
            end
            if (stage_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_byte_reg <= rx_byte;
        end
    end

endmodule

>>> rtl/core/slcd_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_parse
// Next frame state and optional result for one registered byte.
// ----------------------------------------------------------------------------
module slcd_parse
    import slcd_pkg::*;
(
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   sync_value,
    input  frame_state_t cur,
    output frame_state_t nxt,
    output logic         has_result,
    output result_t      result
);

    logic [7:0] count_inc;
    logic [7:0] need;

    assign count_inc = cur.received_count + 8'd1;
    // a zero length behaves as one
    assign need      = (cur.frame_length == 8'd0) ? 8'd1 : cur.frame_length;

    always_comb
    begin
        nxt                  = cur;
        has_result           = 1'b0;
        result.kind          = KIND_PAYLOAD;
        result.payload_byte  = rx_byte;
        result.payload_index = 8'd0;
        if (rx_byte != IDLE_BYTE)
        begin
            unique case (cur.phase)
                PH_HUNT:
                begin
                    if (rx_byte == sync_value)
                    begin
                        nxt.phase = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    nxt.frame_length   = rx_byte;
                    nxt.running_sum    = rx_byte;
                    nxt.received_count = 8'd0;
                    nxt.phase          = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    has_result           = 1'b1;
                    result.payload_index = cur.received_count;
                    nxt.running_sum      = cur.running_sum + rx_byte;
                    nxt.received_count   = count_inc;
                    if (count_inc >= need)
                    begin
                        nxt.phase = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    has_result  = 1'b1;
                    result.kind = (rx_byte == cur.running_sum) ? KIND_GOOD : KIND_BAD;
                    nxt.phase   = PH_HUNT;
                end
                default:
                begin
                    nxt.phase = PH_HUNT;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/slcd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_out_reg
// Result register holding one word until the sink takes it.
// ----------------------------------------------------------------------------
module slcd_out_reg
    import slcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    result,
    output logic       free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid     = valid_reg;
    assign kind          = data_reg.kind;
    assign payload_byte  = data_reg.payload_byte;
    assign payload_index = data_reg.payload_index;

endmodule
